// ===== sv/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
    localparam int WORD_BITS = 64;
    localparam int DATA_BITS = 4 * WORD_BITS;
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_NEG = 3'd4, OP_INV = 3'd5, OP_ABS = 3'd6, OP_SIMP = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_ZGCD = 2'd2
    } status_t;

    // Command to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic div;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
    } unit_req_t;

    // Response from the shared unit: magnitudes, quotient or low product.
    typedef struct packed {
        logic done;
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] rem;
        logic hi_nz;
    } unit_rsp_t;

    function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
        mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction
endpackage

// ===== sv/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit.
//  channel | dir | tdata (low bit up)                        | tuser
//  s_axis  | in  | a_num[63:0] a_den b_num b_den             | req_type[2:0]
//  m_axis  | out | res_num[63:0] res_den                     | status[1:0]
// Add/sub take three products from the shared unit; mul/div take two.
// Simplify takes one division per Euclid step plus two quotients;
// the shared multiply/divide unit performs all of these. Unary ops do not use it.
// One word at a time: s_axis_tready is low from accept until the result is taken.
// Reset clears the sequencer state and the unit's busy and done flags only.
module rational_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // res_num, res_den
    output logic [1:0]   m_axis_tuser   // status
);
    import rau_pkg::*;

    unit_req_t ureq;
    unit_rsp_t ursp;

    rau_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tuser),
        .an(s_axis_tdata[63:0]), .ad(s_axis_tdata[127:64]),
        .bn(s_axis_tdata[191:128]), .bd(s_axis_tdata[255:192]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .rn(m_axis_tdata[63:0]), .rd(m_axis_tdata[127:64]), .st(m_axis_tuser),
        .ureq(ureq), .ursp(ursp)
    );

    rau_unit u_unit (.clk(clk), .rst_n(rst_n), .req(ureq), .rsp(ursp));
endmodule

// ===== sv/rau_unit.sv =====
// Shared shift-add multiplier and restoring divider on unsigned magnitudes.
module rau_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::unit_req_t req,
    output rau_pkg::unit_rsp_t rsp
);
    import rau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 div_reg, div_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] a_reg, a_next;     // multiplicand / quotient shift
    logic [WORD_BITS-1:0] b_reg, b_next;     // multiplier / divisor
    logic [WORD_BITS:0]   acc_reg, acc_next; // high product / remainder
    logic [WORD_BITS-1:0] lo_reg, lo_next;   // low product
    logic                 hnz_reg, hnz_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   trial;

    // one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        hnz_next  = hnz_reg;
        done_next = 1'b0;
        sum   = acc_reg + {1'b0, (b_reg[0] ? a_reg : '0)};
        trial = {acc_reg[WORD_BITS-1:0], a_reg[WORD_BITS-1]} - {1'b0, b_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.div;
            cnt_next  = '0;
            a_next    = req.x;
            b_next    = req.y;
            acc_next  = '0;
            lo_next   = '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[WORD_BITS])
                    acc_next = trial;
                else
                    acc_next = {acc_reg[WORD_BITS-1:0], a_reg[WORD_BITS-1]};
                a_next = {a_reg[WORD_BITS-2:0], ~trial[WORD_BITS]};
            end
            else
            begin
                // shift product right: sum bit 0 into low word
                lo_next  = {sum[0], lo_reg[WORD_BITS-1:1]};
                acc_next = sum >> 1;
                b_next   = b_reg >> 1;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                hnz_next  = div_reg ? 1'b0 : ((sum >> 1) != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        hnz_reg <= hnz_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.lo    = div_reg ? a_reg : lo_reg;
    assign rsp.rem   = acc_reg[WORD_BITS-1:0];
    assign rsp.hi_nz = hnz_reg;
endmodule

// ===== sv/rau_seq.sv =====
// Sequencer: issues products and divisions to the shared unit and builds the result.
module rau_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [rau_pkg::WORD_BITS-1:0] an,
    input  logic [rau_pkg::WORD_BITS-1:0] ad,
    input  logic [rau_pkg::WORD_BITS-1:0] bn,
    input  logic [rau_pkg::WORD_BITS-1:0] bd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [rau_pkg::WORD_BITS-1:0] rn,
    output logic [rau_pkg::WORD_BITS-1:0] rd,
    output logic [1:0]        st,
    output rau_pkg::unit_req_t ureq,
    input  rau_pkg::unit_rsp_t ursp
);
    import rau_pkg::*;

    localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MUL = 6'b000010, S_WAIT = 6'b000100,
        S_GCD  = 6'b001000, S_QDIV = 6'b010000, S_OUT = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [WORD_BITS-1:0] an_reg, an_next, ad_reg, ad_next;
    logic [WORD_BITS-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic [WORD_BITS-1:0] x_reg, x_next, y_reg, y_next;  // gcd pair
    logic [WORD_BITS-1:0] p_reg, p_next;                 // first product
    logic [1:0]           k_reg, k_next;                 // step index
    logic [WORD_BITS-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic                 ovf_reg, ovf_next;
    logic [1:0]           st_reg, st_next;
    logic [WORD_BITS-1:0] opx, opy, sres, sum;
    logic                 sneg_r, sovf;

    // operands for the current step
    always_comb
    begin
        opx = an_reg;
        opy = bd_reg;
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                opx = (k_reg == 2'd0) ? an_reg : (k_reg == 2'd1) ? bn_reg : ad_reg;
                opy = (k_reg == 2'd0) ? bd_reg : (k_reg == 2'd1) ? ad_reg : bd_reg;
            end
            OP_MUL:
            begin
                opx = (k_reg == 2'd0) ? an_reg : ad_reg;
                opy = (k_reg == 2'd0) ? bn_reg : bd_reg;
            end
            OP_DIV:
            begin
                opx = (k_reg == 2'd0) ? an_reg : ad_reg;
                opy = (k_reg == 2'd0) ? bd_reg : bn_reg;
            end
            default:
            begin
                opx = (k_reg == 2'd0) ? an_reg : ad_reg;
                opy = x_reg;
            end
        endcase
    end

    // sign fix of the unit result
    always_comb
    begin
        sneg_r = opx[WORD_BITS-1] ^ opy[WORD_BITS-1];
        sres   = sneg_r ? (~ursp.lo + 1'b1) : ursp.lo;
        // a full-width quotient is kept as a wrapped word and raises no status
        if (state_reg == S_QDIV)
            sovf = 1'b0;
        else
            sovf = ursp.hi_nz || (sneg_r ? (ursp.lo > SMIN) : ursp.lo[WORD_BITS-1]);
        sum = (op_reg == OP_SUB) ? (p_reg - sres) : (p_reg + sres);
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        x_next = x_reg; y_next = y_reg; p_next = p_reg; k_next = k_reg;
        rn_next = rn_reg; rd_next = rd_reg; ovf_next = ovf_reg; st_next = st_reg;
        ureq = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op; an_next = an; ad_next = ad; bn_next = bn; bd_next = bd;
                    x_next = an; y_next = ad; k_next = '0; ovf_next = 1'b0;
                    st_next = ST_OK;
                    case (op)
                        OP_NEG, OP_ABS:
                        begin
                            rd_next = ad;
                            if (op == OP_NEG || an[WORD_BITS-1])
                            begin
                                rn_next = ~an + 1'b1;
                                if (an == SMIN)
                                    st_next = ST_OVF;
                            end
                            else
                                rn_next = an;
                            state_next = S_OUT;
                        end
                        OP_INV:
                        begin
                            rn_next = ad; rd_next = an; state_next = S_OUT;
                        end
                        OP_SIMP: state_next = S_GCD;
                        default: state_next = S_MUL;
                    endcase
                end
            end
            S_MUL:
            begin
                ureq.start = 1'b1; ureq.div = 1'b0;
                ureq.x = mag(opx); ureq.y = mag(opy);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (ursp.done)
                begin
                    ovf_next = ovf_reg | sovf;
                    k_next = k_reg + 1'b1;
                    state_next = S_MUL;
                    if (op_reg == OP_ADD || op_reg == OP_SUB)
                    begin
                        if (k_reg == 2'd0)
                            p_next = sres;
                        else if (k_reg == 2'd1)
                        begin
                            rn_next = sum;
                            if ((p_reg[WORD_BITS-1] ^ sres[WORD_BITS-1]
                                 ^ (op_reg == OP_ADD))
                                && (sum[WORD_BITS-1] != p_reg[WORD_BITS-1]))
                                ovf_next = 1'b1;
                        end
                        else
                        begin
                            rd_next = sres; state_next = S_OUT;
                        end
                    end
                    else if (k_reg == 2'd0)
                        rn_next = sres;
                    else
                    begin
                        rd_next = sres; state_next = S_OUT;
                    end
                    if (state_next == S_OUT)
                        st_next = (ovf_next) ? ST_OVF : ST_OK;
                end
            end
            S_GCD:
            begin
                // one remainder per pass through the divider
                if (!ureq.start && y_reg == '0 && !k_reg[1])
                begin
                    if (x_reg == '0)
                    begin
                        rn_next = '0; rd_next = '0; st_next = ST_ZGCD;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next = '0; state_next = S_QDIV;
                        ureq.start = 1'b1; ureq.div = 1'b1;
                        ureq.x = mag(an_reg); ureq.y = mag(x_reg);
                        k_next = 2'd0;
                    end
                end
                else if (!k_reg[1])
                begin
                    ureq.start = 1'b1; ureq.div = 1'b1;
                    ureq.x = mag(x_reg); ureq.y = mag(y_reg);
                    k_next = 2'd2;
                end
                else if (ursp.done)
                begin
                    x_next = y_reg;
                    y_next = x_reg[WORD_BITS-1] ? (~ursp.rem + 1'b1) : ursp.rem;
                    k_next = 2'd0;
                end
            end
            S_QDIV:
            begin
                if (ursp.done)
                begin
                    ovf_next = ovf_reg | sovf;
                    if (k_reg == 2'd0)
                    begin
                        rn_next = sres; k_next = 2'd1;
                        ureq.start = 1'b1; ureq.div = 1'b1;
                        ureq.x = mag(ad_reg); ureq.y = mag(x_reg);
                    end
                    else
                    begin
                        rd_next = sres;
                        st_next = ovf_next ? ST_OVF : ST_OK;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; an_reg <= an_next; ad_reg <= ad_next;
        bn_reg <= bn_next; bd_reg <= bd_next; x_reg <= x_next; y_reg <= y_next;
        p_reg <= p_next; k_reg <= k_next; rn_reg <= rn_next; rd_reg <= rd_next;
        ovf_reg <= ovf_next; st_reg <= st_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign rn = rn_reg;
    assign rd = rd_reg;
    assign st = st_reg;
endmodule

// ===== sv/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit.
module rau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("took second word");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad status");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] W_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam int NUM_ITEMS = 1650;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [63:0] num;
        logic [63:0] den;
        logic [1:0]  status;
    } frac_res_t;

    typedef struct {
        op_t         op;
        logic [63:0] an, ad, bn, bd;
        bit          typed;
        frac_res_t   res;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [255:0] s_data = '0;
    logic [2:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;
    logic [1:0]   m_user;

    frac_res_t  pending_q[$];
    stim_row_t  rows_q[$];
    int         errors = 0;
    int         sent = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    bit         hold_done = 0;

    rational_arithmetic_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // a_num, a_den, b_num, b_den
        .s_axis_tuser  (s_user),   // req_type
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // res_num, res_den
        .m_axis_tuser  (m_user)    // status
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- fraction predictor ----------------
    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] wmul(input logic [63:0] x, input logic [63:0] y,
                                         inout bit ovf);
        logic [127:0] p;
        logic [63:0]  limit;
        bit           neg;
        p = {64'b0, abs64(x)} * {64'b0, abs64(y)};
        neg = x[63] ^ y[63];
        limit = neg ? W_MIN : W_MAX;
        if (p[127:64] != 0 || p[63:0] > limit)
            ovf = 1;
        return neg ? -p[63:0] : p[63:0];
    endfunction

    function automatic logic [63:0] wadd(input logic [63:0] x, input logic [63:0] y,
                                         input bit sub, inout bit ovf);
        logic [63:0] s;
        bit          same;
        s = sub ? x - y : x + y;
        same = sub ? (x[63] != y[63]) : (x[63] == y[63]);
        if (same && s[63] != x[63])
            ovf = 1;
        return s;
    endfunction

    function automatic logic [63:0] wneg(input logic [63:0] x, inout bit ovf);
        if (x == W_MIN)
            ovf = 1;
        return -x;
    endfunction

    function automatic logic [63:0] trunc_rem(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        r = abs64(x) % abs64(y);
        return x[63] ? -r : r;
    endfunction

    function automatic logic [63:0] trunc_quo(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] q;
        q = abs64(x) / abs64(y);
        return (x[63] != y[63]) ? -q : q;
    endfunction

    function automatic frac_res_t predict_fraction(input op_t op,
                                                   input logic [63:0] an, ad, bn, bd);
        frac_res_t   r;
        bit          ovf;
        logic [63:0] p, q, x, y, c;
        ovf = 0;
        r.num = '0;
        r.den = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD, OP_SUB:
            begin
                p = wmul(an, bd, ovf);
                q = wmul(bn, ad, ovf);
                r.num = wadd(p, q, op == OP_SUB, ovf);
                r.den = wmul(ad, bd, ovf);
            end
            OP_MUL:
            begin
                r.num = wmul(an, bn, ovf);
                r.den = wmul(ad, bd, ovf);
            end
            OP_DIV:
            begin
                r.num = wmul(an, bd, ovf);
                r.den = wmul(ad, bn, ovf);
            end
            OP_NEG:
            begin
                r.num = wneg(an, ovf);
                r.den = ad;
            end
            OP_INV:
            begin
                r.num = ad;
                r.den = an;
            end
            OP_ABS:
            begin
                r.num = an[63] ? wneg(an, ovf) : an;
                r.den = ad;
            end
            default:
            begin
                // Euclid with truncating remainder; GCD keeps its C sign
                x = an;
                y = ad;
                while (y != 0)
                begin
                    c = trunc_rem(x, y);
                    x = y;
                    y = c;
                end
                if (x == 0)
                    r.status = ST_ZGCD;
                else
                begin
                    r.num = trunc_quo(an, x);
                    r.den = trunc_quo(ad, x);
                end
            end
        endcase
        if (r.status == ST_OK && ovf)
            r.status = ST_OVF;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic add_row(input op_t op, input logic [63:0] an, ad, bn, bd,
                           input bit typed, input logic [63:0] en, ed,
                           input status_t est);
        stim_row_t row;
        row.op = op;
        row.an = an;
        row.ad = ad;
        row.bn = bn;
        row.bd = bd;
        row.typed = typed;
        row.res.num = en;
        row.res.den = ed;
        row.res.status = est;
        rows_q.push_back(row);
    endtask

    function automatic logic [63:0] rand_operand(input bit keep_small);
        longint v;
        int     pick;
        pick = keep_small ? $urandom_range(4, 8) : $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: v = {$urandom, $urandom};
            4, 5, 6, 7: v = int'($urandom_range(0, 400)) - 200;
            8:
            begin
                case ($urandom_range(0, 3))
                    0: v = W_MIN;
                    1: v = W_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    function automatic int sender_idle_pct();
        if (sent < NUM_ITEMS / 3)
            return 32;
        else if (sent < 2 * NUM_ITEMS / 3)
            return 69;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent < NUM_ITEMS / 3)
            return 69;
        else if (sent < 2 * NUM_ITEMS / 3)
            return 32;
        return 0;
    endfunction

    // Offer one request word and wait for it to be taken
    task automatic send_request(input stim_row_t row);
        if ($urandom_range(0, 99) < sender_idle_pct())
        begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {row.bd, row.bn, row.ad, row.an};
        s_user <= row.op;
        do
            @(posedge clk);
        while (!s_ready);
        pending_q.push_back(row.typed ? row.res
                            : predict_fraction(row.op, row.an, row.ad, row.bn, row.bd));
        sent++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
        errors++;
        $display("mismatch on result %0d: %s got %h expected %h",
                 results_seen, what, got, exp_v);
    endtask

    // ---------------- result checker and ready pattern ----------------
    always @(posedge clk or negedge rst_n)
    begin
        frac_res_t e;
        if (!rst_n)
            m_ready <= 1'b0;
        else
        begin
            if (m_valid && m_ready)
            begin
                if (pending_q.size() == 0)
                    report_mismatch("unexpected word", {62'b0, m_user}, '0);
                else
                begin
                    e = pending_q.pop_front();
                    if (m_data[63:0] !== e.num)
                        report_mismatch("res_num", m_data[63:0], e.num);
                    if (m_data[127:64] !== e.den)
                        report_mismatch("res_den", m_data[127:64], e.den);
                    if (m_user !== e.status)
                        report_mismatch("status", {62'b0, m_user}, {62'b0, e.status});
                end
                results_seen++;
            end
            // one long hold-off while the sender keeps offering
            if (!hold_done && results_seen == 400)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        stim_row_t row;
        op_t       op;
        bit        keep_small;
        int        drain;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: extremes, every opcode, simplify corner cases
        add_row(OP_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK);
        add_row(OP_SUB, 1, 2, 1, 3, 0, 0, 0, ST_OK);
        add_row(OP_ADD, W_MAX, 1, W_MAX, 1, 0, 0, 0, ST_OK);
        add_row(OP_SUB, W_MIN, 1, 1, 1, 0, 0, 0, ST_OK);
        add_row(OP_MUL, W_MAX, 3, 2, 5, 0, 0, 0, ST_OK);
        add_row(OP_MUL, W_MIN, -1, -1, 1, 0, 0, 0, ST_OK);
        add_row(OP_MUL, W_MIN, 1, 1, 1, 0, 0, 0, ST_OK);
        add_row(OP_DIV, 3, 4, 5, 7, 0, 0, 0, ST_OK);
        add_row(OP_DIV, W_MAX, W_MIN, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_NEG, W_MIN, 1, 0, 0, 1, W_MIN, 1, ST_OVF);
        add_row(OP_NEG, W_MAX, -1, 0, 0, 1, W_MIN + 1, -1, ST_OK);
        add_row(OP_INV, 0, 5, 0, 0, 1, 5, 0, ST_OK);
        add_row(OP_INV, W_MIN, W_MAX, 0, 0, 1, W_MAX, W_MIN, ST_OK);
        add_row(OP_ABS, -3, 4, 0, 0, 1, 3, 4, ST_OK);
        add_row(OP_ABS, W_MIN, 2, 0, 0, 1, W_MIN, 2, ST_OVF);
        add_row(OP_SIMP, 0, 0, 0, 0, 1, 0, 0, ST_ZGCD);
        add_row(OP_SIMP, 0, -7, 0, 0, 1, 0, 1, ST_OK);
        add_row(OP_SIMP, 9, 0, 0, 0, 1, 1, 0, ST_OK);
        add_row(OP_SIMP, 6, -4, 0, 0, 1, 3, -2, ST_OK);
        add_row(OP_SIMP, W_MIN, -1, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_SIMP, W_MIN, W_MIN, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_SIMP, W_MAX, W_MAX - 1, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_SIMP, -1, W_MIN, 0, 0, 0, 0, 0, ST_OK);
        foreach (rows_q[i])
            send_request(rows_q[i]);

        // random requests
        while (sent < NUM_ITEMS)
        begin
            if (sent == NUM_ITEMS / 2)
            begin
                // let the block drain completely before going on
                s_valid <= 1'b0;
                @(posedge clk);
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            op = op_t'($urandom_range(0, 7));
            keep_small = (op == OP_SIMP) && ($urandom_range(0, 3) != 0);
            row.op = op;
            row.an = rand_operand(keep_small);
            row.ad = rand_operand(keep_small);
            row.bn = rand_operand(0);
            row.bd = rand_operand(0);
            row.typed = 0;
            send_request(row);
        end
        s_valid <= 1'b0;

        // drain, then a short tail for stray words
        while (pending_q.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < 50; drain++)
            @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
